// File: hdl/ivmbrs_pkg.sv
// Package for the integer vector-matrix unit with bias, ReLU and saturation.
// Holds the sizes, register codes, output type codes and the stage control word.
// No dependencies; every other file of the block but ivmbrs_ram imports it.
`default_nettype none

package ivmbrs_pkg;

  localparam int DataW      = 64;
  localparam int StoreDepth = 256;
  localparam int AddrW      = $clog2(StoreDepth);
  localparam int SizeW      = AddrW + 1;
  localparam int MaxRows    = 256;
  localparam int MaxCols    = 256;
  localparam int RowLim     = (MaxRows < StoreDepth) ? MaxRows : StoreDepth;
  localparam int ColLim     = (MaxCols < StoreDepth) ? MaxCols : StoreDepth;

  localparam int CfgAddrW   = 3;
  localparam int CfgDataW   = SizeW;

  // Stream payload layout.
  localparam int InDataW    = 136;
  localparam int OutDataW   = 72;

  // Saturation bounds for the narrow output types.
  localparam logic [DataW-1:0] SatMin8  = 64'hFFFF_FFFF_FFFF_FF80;
  localparam logic [DataW-1:0] SatMax8  = 64'h0000_0000_0000_007F;
  localparam logic [DataW-1:0] SatMin16 = 64'hFFFF_FFFF_FFFF_8000;
  localparam logic [DataW-1:0] SatMax16 = 64'h0000_0000_0000_7FFF;
  localparam logic [DataW-1:0] SatMin32 = 64'hFFFF_FFFF_8000_0000;
  localparam logic [DataW-1:0] SatMax32 = 64'h0000_0000_7FFF_FFFF;

  typedef enum logic [CfgAddrW-1:0] {
    CfgRowsUsed  = 3'd0,
    CfgColsUsed  = 3'd1,
    CfgBiasEn    = 3'd2,
    CfgReluEn    = 3'd3,
    CfgSatEn     = 3'd4,
    CfgOutType   = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    OutInt8  = 2'd0,
    OutInt16 = 2'd1,
    OutInt32 = 2'd2,
    OutInt64 = 2'd3
  } out_type_e;

  typedef enum logic {
    ActLoad   = 1'b0,
    ActWeight = 1'b1
  } action_e;

  // Control that travels with a weight through the pipeline.
  typedef struct packed {
    logic             first;
    logic             last_row;
    logic [AddrW-1:0] col;
    logic             last_col;
  } ctl_t;

endpackage

`default_nettype wire

// File: hdl/int_vector_matrix_bias_relu_sat.sv
// Integer vector-matrix product y = x*W (+b) with optional ReLU and saturation.
//
// Input stream: each word is either a load (tuser = 0) that writes x[vec_index]
// into the vector store, or a weight (tuser = 1). Weights arrive column-major,
// rows_used weights per column; the bias in the word is taken on row zero.
// Output stream: one word per finished column with its result and column
// number; tlast marks the final column of the output vector.
// Configuration: plain write port, register index on cfg_addr_i. Write only
// while no results are outstanding.
//
// Throughput: one input word per cycle while the output is not stalled. The
// result of a column passes the vector store read, partial products, product
// sum, accumulate and output register after its last weight is accepted. The
// 64-bit product is built from three 32x32 multipliers in one stage.
// Reset clears the counters, the accumulator and the configuration (rows 1,
// cols 1, bias/ReLU/saturation off, int64 out). The store is not cleared.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and s_axis_tready_o drops until the word is taken.
`default_nettype none

module int_vector_matrix_bias_relu_sat (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid_i,
  output      logic                              s_axis_tready_o,
  // [7:0] vec_index, [71:8] elem_value, [135:72] bias_value
  input  wire logic [ivmbrs_pkg::InDataW-1:0]    s_axis_tdata_i,
  // [0] action
  input  wire logic                              s_axis_tuser_i,
  output      logic                              m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  // [63:0] result, [71:64] col_index
  output      logic [ivmbrs_pkg::OutDataW-1:0]   m_axis_tdata_o,
  output      logic                              m_axis_tlast_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [ivmbrs_pkg::CfgAddrW-1:0]   cfg_addr_i,
  input  wire logic [ivmbrs_pkg::CfgDataW-1:0]   cfg_wdata_i
);

  import ivmbrs_pkg::*;

  // Configuration registers.
  logic [SizeW-1:0] rows_used_q, cols_used_q;
  logic             bias_en_q, relu_en_q, sat_en_q;
  out_type_e        out_type_q;

  // Input unpacking.
  logic [AddrW-1:0] in_index;
  logic [DataW-1:0] in_elem, in_bias;
  logic             advance, in_acc, load_acc, weight_acc;

  // Counters.
  logic [AddrW-1:0] row_cnt_q, col_cnt_q;
  logic [SizeW-1:0] rows_eff, cols_eff;
  logic             last_row, last_col;

  // Pipeline.
  logic             s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q;
  ctl_t             s1_ctl_q, s2_ctl_q, s3_ctl_q;
  logic [DataW-1:0] s1_w_q, s1_bias_q, s2_bias_q, s3_bias_q;
  logic [DataW-1:0] x_rd;
  logic [31:0]      x_lo, x_hi, w_lo, w_hi;
  logic [DataW-1:0] p_ll_q;
  logic [31:0]      p_lh_q, p_hl_q, cross_sum;
  logic [DataW-1:0] prod_q, acc_q;
  logic [AddrW-1:0] s4_col_q;
  logic             s4_last_q;

  // Output register.
  logic             out_valid_q;
  logic [DataW-1:0] out_result_q;
  logic [AddrW-1:0] out_col_q;
  logic             out_last_q;

  assign in_index = s_axis_tdata_i[AddrW-1:0];
  assign in_elem  = s_axis_tdata_i[AddrW +: DataW];
  assign in_bias  = s_axis_tdata_i[AddrW+DataW +: DataW];

  assign advance         = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = advance;
  assign in_acc          = s_axis_tvalid_i && advance;
  assign load_acc        = in_acc && (action_e'(s_axis_tuser_i) == ActLoad);
  assign weight_acc      = in_acc && (action_e'(s_axis_tuser_i) == ActWeight);

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_used_q <= SizeW'(1);
      cols_used_q <= SizeW'(1);
      bias_en_q   <= 1'b0;
      relu_en_q   <= 1'b0;
      sat_en_q    <= 1'b0;
      out_type_q  <= OutInt64;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        CfgRowsUsed: rows_used_q <= cfg_wdata_i;
        CfgColsUsed: cols_used_q <= cfg_wdata_i;
        CfgBiasEn:   bias_en_q   <= cfg_wdata_i[0];
        CfgReluEn:   relu_en_q   <= cfg_wdata_i[0];
        CfgSatEn:    sat_en_q    <= cfg_wdata_i[0];
        CfgOutType:  out_type_q  <= out_type_e'(cfg_wdata_i[1:0]);
        default: ;
      endcase
    end
  end

  // Zero sizes act as one, oversized ones as the store limit.
  always_comb begin
    rows_eff = rows_used_q;
    if (rows_used_q == '0) begin
      rows_eff = SizeW'(1);
    end else if (rows_used_q > SizeW'(RowLim)) begin
      rows_eff = SizeW'(RowLim);
    end
    cols_eff = cols_used_q;
    if (cols_used_q == '0) begin
      cols_eff = SizeW'(1);
    end else if (cols_used_q > SizeW'(ColLim)) begin
      cols_eff = SizeW'(ColLim);
    end
  end

  assign last_row = ({1'b0, row_cnt_q} + SizeW'(1)) >= rows_eff;
  assign last_col = ({1'b0, col_cnt_q} + SizeW'(1)) >= cols_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cnt_q <= '0;
      col_cnt_q <= '0;
    end else if (weight_acc) begin
      if (last_row) begin
        row_cnt_q <= '0;
        col_cnt_q <= last_col ? '0 : col_cnt_q + AddrW'(1);
      end else begin
        row_cnt_q <= row_cnt_q + AddrW'(1);
      end
    end
  end

  // Vector store: loads write, weights read the entry of their row.
  ivmbrs_ram #(
    .Width (DataW),
    .Depth (StoreDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (load_acc),
    .waddr_i (in_index),
    .wdata_i (in_elem),
    .re_i    (weight_acc),
    .raddr_i (row_cnt_q),
    .rdata_o (x_rd)
  );

  assign x_lo = x_rd[31:0];
  assign x_hi = x_rd[63:32];
  assign w_lo = s1_w_q[31:0];
  assign w_hi = s1_w_q[63:32];
  assign cross_sum = p_lh_q + p_hl_q;

  // Valid bits and the accumulator.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      acc_q       <= '0;
    end else if (advance) begin
      s1_valid_q  <= weight_acc;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      s4_valid_q  <= s3_valid_q && s3_ctl_q.last_row;
      out_valid_q <= s4_valid_q;
      if (s3_valid_q) begin
        acc_q <= (s3_ctl_q.first ? s3_bias_q : acc_q) + prod_q;
      end
    end
  end

  // ReLU, saturation to the output type, then truncation with sign extension.
  function automatic logic [DataW-1:0] finish(input logic [DataW-1:0] sum);
    logic [DataW-1:0] v, hi, lo, res;
    v  = (relu_en_q && sum[DataW-1]) ? '0 : sum;
    hi = SatMax32;
    lo = SatMin32;
    case (out_type_q)
      OutInt8:  begin hi = SatMax8;  lo = SatMin8;  end
      OutInt16: begin hi = SatMax16; lo = SatMin16; end
      default:  begin hi = SatMax32; lo = SatMin32; end
    endcase
    if (relu_en_q) begin
      lo = '0;
    end
    if (sat_en_q && (out_type_q != OutInt64)) begin
      if ($signed(v) < $signed(lo)) begin
        v = lo;
      end
      if ($signed(v) > $signed(hi)) begin
        v = hi;
      end
    end
    case (out_type_q)
      OutInt8:  res = {{56{v[7]}}, v[7:0]};
      OutInt16: res = {{48{v[15]}}, v[15:0]};
      OutInt32: res = {{32{v[31]}}, v[31:0]};
      default:  res = v;
    endcase
    return res;
  endfunction

  // Payload stages.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_ctl_q.first    <= (row_cnt_q == '0);
      s1_ctl_q.last_row <= last_row;
      s1_ctl_q.col      <= col_cnt_q;
      s1_ctl_q.last_col <= last_col;
      s1_w_q            <= in_elem;
      s1_bias_q         <= bias_en_q ? in_bias : '0;

      // Low 64 bits of the 64x64 product from three 32x32 products.
      s2_ctl_q  <= s1_ctl_q;
      s2_bias_q <= s1_bias_q;
      p_ll_q    <= DataW'(x_lo) * DataW'(w_lo);
      p_lh_q    <= x_lo * w_hi;
      p_hl_q    <= x_hi * w_lo;

      s3_ctl_q  <= s2_ctl_q;
      s3_bias_q <= s2_bias_q;
      prod_q    <= p_ll_q + {cross_sum, 32'h0};

      s4_col_q  <= s3_ctl_q.col;
      s4_last_q <= s3_ctl_q.last_col;

      out_result_q <= finish(acc_q);
      out_col_q    <= s4_col_q;
      out_last_q   <= s4_last_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_col_q, out_result_q};
  assign m_axis_tlast_o  = out_last_q;

endmodule

`default_nettype wire

// File: hdl/ivmbrs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; used for the input vector store.
`default_nettype none

module ivmbrs_ram #(
  parameter int Width = 64,
  parameter int Depth = 256
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                          wdata_i,
  input  wire logic                                      re_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output      logic [Width-1:0]                          rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: hdl/ivmbrs_chk.sv
// Port-level checker for the integer vector-matrix unit, bound to its top level.
// Depends on ivmbrs_pkg for the register and output type codes.
`default_nettype none

module ivmbrs_chk (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              s_axis_tvalid_i,
  input wire logic                              s_axis_tready_o,
  // [7:0] vec_index, [71:8] elem_value, [135:72] bias_value
  input wire logic [ivmbrs_pkg::InDataW-1:0]    s_axis_tdata_i,
  // [0] action
  input wire logic                              s_axis_tuser_i,
  input wire logic                              m_axis_tvalid_o,
  input wire logic                              m_axis_tready_i,
  // [63:0] result, [71:64] col_index
  input wire logic [ivmbrs_pkg::OutDataW-1:0]   m_axis_tdata_o,
  input wire logic                              m_axis_tlast_o,
  input wire logic                              cfg_we_i,
  input wire logic [ivmbrs_pkg::CfgAddrW-1:0]   cfg_addr_i,
  input wire logic [ivmbrs_pkg::CfgDataW-1:0]   cfg_wdata_i
);

  import ivmbrs_pkg::*;

  // Shadow copies of the registers the checks depend on.
  logic      relu_q;
  logic      sat_q;
  out_type_e type_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      relu_q <= 1'b0;
      sat_q  <= 1'b0;
      type_q <= OutInt64;
    end else if (cfg_we_i) begin
      if (cfg_reg_e'(cfg_addr_i) == CfgReluEn) begin
        relu_q <= cfg_wdata_i[0];
      end
      if (cfg_reg_e'(cfg_addr_i) == CfgSatEn) begin
        sat_q <= cfg_wdata_i[0];
      end
      if (cfg_reg_e'(cfg_addr_i) == CfgOutType) begin
        type_q <= out_type_e'(cfg_wdata_i[1:0]);
      end
    end
  end

  // A stalled output word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("output word changed while stalled");

  // The input side only stalls behind a waiting, untaken result.
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input stalled without a blocked result");

  // Under ReLU no result is negative, unless truncation to a narrow type
  // without saturation wraps it.
  a_relu_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && relu_q && (sat_q || (type_q == OutInt64)) |->
      !m_axis_tdata_o[63])
    else $error("negative result with ReLU enabled");

  // An int8 result is sign-extended from bit 7.
  a_int8_ext: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (type_q == OutInt8) |->
      (&m_axis_tdata_o[63:7]) || !(|m_axis_tdata_o[63:7]))
    else $error("int8 result not sign-extended");

endmodule

bind int_vector_matrix_bias_relu_sat ivmbrs_chk u_ivmbrs_chk (.*);

`default_nettype wire

// File: verif/tb_int_vector_matrix_bias_relu_sat.sv
`timescale 1ns / 100ps
// Self-checking bench for int_vector_matrix_bias_relu_sat: streams loads and weights,
// predicts every column result in-bench and checks the output stream word by word.
// Depends on ivmbrs_pkg and the top level int_vector_matrix_bias_relu_sat only.

module tb_int_vector_matrix_bias_relu_sat;
  import ivmbrs_pkg::*;

  localparam int unsigned CycleLimit   = 600_000;
  localparam int unsigned SettleCycles = 12;
  localparam int unsigned RandomWords  = 2000;

  typedef struct {
    action_e          act;
    logic [7:0]       idx;
    logic [63:0]      elem;
    logic [63:0]      bias;
    int unsigned      gap;
  } vm_word_t;

  typedef struct {
    logic [63:0] value;
    logic [7:0]  col;
    logic        last;
  } col_result_t;

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  // [7:0] vec_index, [71:8] elem_value, [135:72] bias_value
  logic [InDataW-1:0]  s_axis_tdata_i  = '0;
  // [0] action
  logic                s_axis_tuser_i  = 1'b0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  // [63:0] result, [71:64] col_index
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic                m_axis_tlast_o;
  logic                cfg_we_i        = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr_i      = '0;
  logic [CfgDataW-1:0] cfg_wdata_i     = '0;

  int_vector_matrix_bias_relu_sat uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Bench copy of the configuration and the datapath state.
  logic [8:0]  cfg_rows  = 9'd1;
  logic [8:0]  cfg_cols  = 9'd1;
  logic        cfg_bias  = 1'b0;
  logic        cfg_relu  = 1'b0;
  logic        cfg_sat   = 1'b0;
  out_type_e   cfg_otype = OutInt64;
  logic [63:0] x_model [StoreDepth];
  logic [63:0] acc_model = '0;
  int unsigned row_ctr   = 0;
  int unsigned col_ctr   = 0;

  // Generator side: which store entries hold data, and the row the next weight reads.
  bit [StoreDepth-1:0] x_loaded = '0;
  int unsigned         feed_row = 0;
  int unsigned         words_queued = 0;

  vm_word_t    pend_q[$];
  col_result_t col_results_q[$];
  vm_word_t    cur_word;
  logic        in_holding = 1'b0;
  int unsigned in_wait    = 0;
  int unsigned sink_stall = 0;
  bit          in_burst   = 1'b0;
  bit          out_burst  = 1'b0;
  int unsigned mismatches = 0;
  int unsigned cycle_cnt  = 0;

  function automatic int unsigned eff_size(logic [8:0] v, int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  function automatic logic [63:0] shape_output(logic [63:0] sum);
    logic [63:0] lo;
    logic [63:0] hi;
    if (cfg_relu && sum[63]) sum = '0;
    case (cfg_otype)
      OutInt8: begin
        lo = SatMin8;
        hi = SatMax8;
      end
      OutInt16: begin
        lo = SatMin16;
        hi = SatMax16;
      end
      OutInt32: begin
        lo = SatMin32;
        hi = SatMax32;
      end
      default: return sum;
    endcase
    if (cfg_relu) lo = '0;
    if (cfg_sat) begin
      if ($signed(sum) < $signed(lo)) sum = lo;
      if ($signed(sum) > $signed(hi)) sum = hi;
    end
    case (cfg_otype)
      OutInt8:  sum = {{56{sum[7]}}, sum[7:0]};
      OutInt16: sum = {{48{sum[15]}}, sum[15:0]};
      default:  sum = {{32{sum[31]}}, sum[31:0]};
    endcase
    return sum;
  endfunction

  function automatic void accumulate_word(vm_word_t w);
    col_result_t r;
    int unsigned nr;
    int unsigned nc;
    logic        last;
    nr = eff_size(cfg_rows, RowLim);
    nc = eff_size(cfg_cols, ColLim);
    if (w.act == ActLoad) begin
      x_model[w.idx] = w.elem;
      return;
    end
    if (row_ctr == 0) acc_model = cfg_bias ? w.bias : '0;
    acc_model = acc_model + x_model[row_ctr] * w.elem;
    if (row_ctr + 1 < nr) begin
      row_ctr++;
    end else begin
      row_ctr = 0;
      last = (col_ctr + 1 >= nc);
      r.value = shape_output(acc_model);
      r.col = 8'(col_ctr);
      r.last = last;
      col_results_q.push_back(r);
      col_ctr = last ? 0 : col_ctr + 1;
    end
  endfunction

  function automatic void report_mismatch(string what, logic [63:0] want, logic [63:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s differs: expected %h, got %h", $realtime, what, want, got);
  endfunction

  // Mix of extremes, full-width noise and small values that make clamping likely.
  function automatic logic [63:0] pick_value();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0:       return 64'h8000_0000_0000_0000;
      1:       return 64'h7FFF_FFFF_FFFF_FFFF;
      2:       return '0;
      3:       return '1;
      4, 5:    return {$urandom, r};
      6:       return {{32{r[31]}}, r};
      7:       return {{48{r[15]}}, r[15:0]};
      default: return 64'(r[8:0]) - 64'd256;
    endcase
  endfunction

  function automatic void push_word(action_e a, logic [7:0] idx, logic [63:0] e,
                                    logic [63:0] b);
    vm_word_t w;
    w.act = a;
    w.idx = idx;
    w.elem = e;
    w.bias = b;
    w.gap = in_burst ? 0 : $urandom_range(0, 6);
    pend_q.push_back(w);
    words_queued++;
  endfunction

  function automatic void push_load(logic [7:0] idx, logic [63:0] v);
    x_loaded[idx] = 1'b1;
    push_word(ActLoad, idx, v, pick_value());
  endfunction

  // A weight never reads a store entry that was not loaded first.
  function automatic void push_weight(logic [63:0] e, logic [63:0] b);
    if (!x_loaded[feed_row]) push_load(8'(feed_row), pick_value());
    push_word(ActWeight, 8'($urandom), e, b);
    feed_row = (feed_row + 1 < eff_size(cfg_rows, RowLim)) ? feed_row + 1 : 0;
  endfunction

  task automatic set_reg(cfg_reg_e r, logic [8:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= r;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (r)
      CfgRowsUsed: cfg_rows  = v;
      CfgColsUsed: cfg_cols  = v;
      CfgBiasEn:   cfg_bias  = v[0];
      CfgReluEn:   cfg_relu  = v[0];
      CfgSatEn:    cfg_sat   = v[0];
      CfgOutType:  cfg_otype = out_type_e'(v[1:0]);
      default: ;
    endcase
  endtask

  // Waits until every word went in and every result came out, then lets
  // partial-column work finish inside the pipeline.
  task automatic drain();
    do @(posedge clk_i);
    while (pend_q.size() != 0 || in_holding || col_results_q.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic random_phase();
    int unsigned sel;
    int unsigned nr;
    int unsigned nc;
    int unsigned vecs;
    logic [8:0]  rv;
    logic [8:0]  cv;
    drain();
    in_burst  = ($urandom_range(0, 3) == 0);
    out_burst = ($urandom_range(0, 3) == 0);
    sel = $urandom_range(0, 99);
    if (sel < 3) begin
      rv = $urandom_range(0, 1) ? 9'd256 : 9'($urandom_range(257, 511));
      cv = 9'($urandom_range(0, 2));
    end else if (sel < 6) begin
      cv = $urandom_range(0, 1) ? 9'd256 : 9'($urandom_range(257, 511));
      rv = 9'($urandom_range(0, 2));
    end else if (sel < 18) begin
      rv = 9'($urandom_range(13, 40));
      cv = 9'($urandom_range(0, 4));
    end else begin
      rv = 9'($urandom_range(0, 12));
      cv = 9'($urandom_range(0, 6));
    end
    set_reg(CfgRowsUsed, rv);
    set_reg(CfgColsUsed, cv);
    set_reg(CfgBiasEn, 9'($urandom_range(0, 1)));
    set_reg(CfgReluEn, 9'($urandom_range(0, 1)));
    set_reg(CfgSatEn, 9'($urandom_range(0, 1)));
    set_reg(CfgOutType, 9'($urandom_range(0, 3)));
    nr = eff_size(rv, RowLim);
    nc = eff_size(cv, ColLim);
    if ($urandom_range(0, 1)) begin
      for (int unsigned i = 0; i < nr; i++) push_load(8'(i), pick_value());
    end
    vecs = (nr * nc > 200) ? 1 : $urandom_range(1, 3);
    for (int unsigned i = 0; i < vecs * nr * nc; i++) begin
      if ($urandom_range(0, 19) == 0) push_load(8'($urandom), pick_value());
      push_weight(pick_value(), pick_value());
    end
    // Now and then leave a column unfinished so the next setting starts mid-column.
    if ($urandom_range(0, 6) == 0) begin
      repeat ($urandom_range(1, 3)) push_weight(pick_value(), pick_value());
    end
  endtask

  always @(posedge clk_i) begin : feed_in
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        accumulate_word(cur_word);
        in_holding = 1'b0;
      end
      if (!in_holding && pend_q.size() > 0) begin
        if (in_wait < pend_q[0].gap) begin
          in_wait++;
        end else begin
          cur_word = pend_q.pop_front();
          in_wait = 0;
          in_holding = 1'b1;
          s_axis_tdata_i <= {cur_word.bias, cur_word.elem, cur_word.idx};
          s_axis_tuser_i <= cur_word.act;
        end
      end
      s_axis_tvalid_i <= in_holding;
    end
  end

  always @(posedge clk_i) begin : check_out
    col_result_t want;
    logic        take;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (col_results_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result word %h with no column pending", $realtime,
                     m_axis_tdata_o);
        end else begin
          want = col_results_q.pop_front();
          if (m_axis_tdata_o[63:0] !== want.value)
            report_mismatch("result", want.value, m_axis_tdata_o[63:0]);
          if (m_axis_tdata_o[71:64] !== want.col)
            report_mismatch("col_index", 64'(want.col), 64'(m_axis_tdata_o[71:64]));
          if (m_axis_tlast_o !== want.last)
            report_mismatch("last_col", 64'(want.last), 64'(m_axis_tlast_o));
        end
        sink_stall = out_burst ? 0 : $urandom_range(0, 6);
      end
      take = 1'b1;
      if (sink_stall > 0) begin
        sink_stall--;
        take = 1'b0;
      end
      m_axis_tready_i <= take;
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("int_vector_matrix_bias_relu_sat: mismatch");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned dir_words;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset configuration: one row, one column, int64, no bias; products wrap.
    push_load(8'd0, 64'h7FFF_FFFF_FFFF_FFFF);
    push_load(8'd255, 64'h8000_0000_0000_0000);
    push_weight(64'd2, 64'd5);
    push_weight(64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF);

    // Bias on, int8 saturation at both bounds, three columns of two rows.
    drain();
    set_reg(CfgRowsUsed, 9'd2);
    set_reg(CfgColsUsed, 9'd3);
    set_reg(CfgBiasEn, 9'd1);
    set_reg(CfgSatEn, 9'd1);
    set_reg(CfgOutType, 9'(OutInt8));
    push_load(8'd0, 64'd100);
    push_load(8'd1, -64'sd3);
    push_weight(64'd2, 64'd10);
    push_weight(64'd0, 64'd0);
    push_weight(-64'sd5, -64'sd1000);
    push_weight(64'd0, 64'd0);
    push_weight(64'd1, 64'd0);
    push_weight(64'd1, 64'd0);

    // Zero rows acts as one, oversized columns act as the maximum; ReLU with int16.
    drain();
    set_reg(CfgRowsUsed, 9'd0);
    set_reg(CfgColsUsed, 9'd511);
    set_reg(CfgReluEn, 9'd1);
    set_reg(CfgOutType, 9'(OutInt16));
    push_weight('1, 64'h7FFF_FFFF_FFFF_FFFF);
    push_weight(64'd1, -64'sd1_000_000);

    // Shrinking the column count below the running column ends the vector at once.
    drain();
    set_reg(CfgColsUsed, 9'd1);
    set_reg(CfgReluEn, 9'd0);
    set_reg(CfgSatEn, 9'd0);
    set_reg(CfgOutType, 9'(OutInt32));
    push_weight(64'h0000_0001_0000_0001, 64'hFFFF_FFFF_0000_0000);
    drain();
    set_reg(CfgSatEn, 9'd1);
    push_weight(64'd0, 64'h7FFF_FFFF_FFFF_FFFF);
    drain();
    set_reg(CfgOutType, 9'(OutInt64));
    push_weight(64'h7FFF_FFFF_FFFF_FFFF, 64'd0);

    dir_words = words_queued;
    while (words_queued - dir_words < RandomWords) random_phase();

    drain();
    if (mismatches == 0) begin
      $display("int_vector_matrix_bias_relu_sat: match");
    end else begin
      $display("int_vector_matrix_bias_relu_sat: mismatch");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/ivmbrs_pkg.sv
hdl/ivmbrs_ram.sv
hdl/int_vector_matrix_bias_relu_sat.sv
hdl/ivmbrs_chk.sv
verif/tb_int_vector_matrix_bias_relu_sat.sv
